// ===== sv/uer_pkg.sv =====
// Package with shared types and constants for the ultrasonic echo ranging unit.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int TRIG_W   = 10;
  localparam int SCALE_W  = 16;
  localparam int OFFSET_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ECHO_CNT_W = 16;
  localparam int DIST_W     = 20;
  localparam int PHASE_W    = 3;

  localparam int DIST_MAX = 524287;

  localparam logic [TRIG_W-1:0]   TRIG_RST   = 10'd10;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd1181;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 2'd0,
    CFG_SCALE_Q16     = 2'd1,
    CFG_OFFSET_Q8     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_WAIT = 3'd2,
    PH_MEAS = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

endpackage

// ===== sv/ultrasonic_echo_ranging_unit.sv =====
// Top level of the ultrasonic echo ranging unit: phase sequencer, tick counter and distance.
`timescale 1ns / 1ps

//  channel | direction | signals
//  --------+-----------+-------------------------------------------------------------
//  in_     | input     | in_valid, in_ready, in_cmd, in_echo_level
//  out_    | output    | out_valid, out_ready, out_trigger_out, out_phase, out_done_res,
//          |           | out_echo_count, out_distance_q8
//  cfg_    | input     | cfg_valid, cfg_ready, cfg_index, cfg_wdata
//
// Each transaction's result is registered at the accepting edge.
// The distance multiply, subtract and clamp sit between the state and result registers.
// One transaction per cycle is sustained while out_ready stays high.
// When the result register is full and not taken, in_ready drops until it drains.
// Synchronous reset puts the sequencer in idle with a zero count and distance.

module ultrasonic_echo_ranging_unit
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic                         in_echo_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_trigger_out,
  output logic [PHASE_W-1:0]           out_phase,
  output logic                         out_done_res,
  output logic [ECHO_CNT_W-1:0]        out_echo_count,
  output logic signed [DIST_W-1:0]     out_distance_q8,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int SHR_W  = PROD_W - 8;
  localparam int DW     = (SHR_W + 1 > DIST_W + 1) ? SHR_W + 1 : DIST_W + 1;
  localparam int CW     = (COUNT_BITS > TRIG_W) ? COUNT_BITS : TRIG_W;
  localparam logic signed [DW-1:0] DMAX = DW'(DIST_MAX);
  localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);

  logic [TRIG_W-1:0]          trig_r;
  logic [SCALE_W-1:0]         scale_r;
  logic [OFFSET_W-1:0]        offset_r;

  phase_t                     phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]      count_r, count_nxt, count_inc;
  logic signed [DIST_W-1:0]   dist_r, dist_nxt;

  logic                       out_valid_r;
  logic                       trig_out_r;
  logic [PHASE_W-1:0]         phase_out_r;
  logic                       done_r, done_nxt;
  logic [ECHO_CNT_W-1:0]      echo_cnt_r, echo_cnt_nxt;
  logic signed [DIST_W-1:0]   dist_out_r;

  logic [PROD_W-1:0]          prod;
  logic [SHR_W-1:0]           prod_shr;
  logic signed [DW-1:0]       diff;
  logic signed [DIST_W-1:0]   dist_calc;
  logic                       in_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r   <= TRIG_RST;
      scale_r  <= SCALE_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRIGGER_TICKS: trig_r   <= cfg_wdata[TRIG_W-1:0];
        CFG_SCALE_Q16:     scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_OFFSET_Q8:     offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_inc = (count_r == '1) ? count_r : count_r + COUNT_BITS'(1);

  assign prod     = PROD_W'(count_r) * PROD_W'(scale_r);
  assign prod_shr = prod[PROD_W-1:8];
  assign diff     = $signed(DW'(prod_shr)) - $signed(DW'(offset_r));

  always_comb begin
    if (diff > DMAX) begin
      dist_calc = DMAX[DIST_W-1:0];
    end else if (diff < DMIN) begin
      dist_calc = DMIN[DIST_W-1:0];
    end else begin
      dist_calc = diff[DIST_W-1:0];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    dist_nxt  = dist_r;
    done_nxt  = 1'b0;
    if (in_cmd == CMD_START) begin
      phase_nxt = PH_TRIG;
      count_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_TRIG: begin
          if (CW'(count_inc) > CW'(trig_r)) begin
            count_nxt = '0;
            phase_nxt = PH_WAIT;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_WAIT: begin
          if (in_echo_level) begin
            phase_nxt = PH_MEAS;
          end
        end
        PH_MEAS: begin
          if (in_echo_level) begin
            count_nxt = count_inc;
          end else begin
            dist_nxt  = dist_calc;
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  generate
    if (COUNT_BITS > ECHO_CNT_W) begin : g_cnt_sat
      assign echo_cnt_nxt = (|count_nxt[COUNT_BITS-1:ECHO_CNT_W]) ? '1
                                                                   : count_nxt[ECHO_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign echo_cnt_nxt = ECHO_CNT_W'(count_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        dist_r      <= dist_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      trig_out_r  <= (phase_nxt == PH_TRIG);
      phase_out_r <= phase_nxt;
      done_r      <= done_nxt;
      echo_cnt_r  <= echo_cnt_nxt;
      dist_out_r  <= (phase_nxt == PH_DONE) ? dist_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger_out = trig_out_r;
  assign out_phase       = phase_out_r;
  assign out_done_res    = done_r;
  assign out_echo_count  = echo_cnt_r;
  assign out_distance_q8 = dist_out_r;

  a_trig_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trigger_out == (out_phase == PH_TRIG)))
    else $error("trigger output disagrees with phase");

  a_done_in_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_phase == PH_DONE))
    else $error("done flagged outside the done phase");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == CMD_START)) |=>
      (out_valid && (out_phase == PH_TRIG) && (out_echo_count == '0)))
    else $error("start transaction did not restart the trigger phase");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_echo_count)
                                   && $stable(out_phase)))
    else $error("stalled result was dropped or changed");

endmodule
